// ----- design/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int KEY_W      = 31;
   localparam int VALUE_W    = 16;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 4;

   // Home slot reduction: key is padded to HASH_W and consumed DIGIT_W bits a cycle
   localparam int HASH_W     = 32;
   localparam int DIGIT_W    = 4;
   localparam int HASH_STEPS = HASH_W / DIGIT_W;
   localparam int STEP_W     = $clog2(HASH_STEPS);

   // action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_SEARCH = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] RES_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] RES_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] RES_FOUND    = 3'd2;
   localparam logic [STATUS_W-1:0] RES_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] RES_DELETED  = 3'd4;

   // slot state codes
   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_USED  = 2'd1;
   localparam logic [1:0] SLOT_TOMB  = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [VALUE_W-1:0]    value_out;
      logic [SLOT_OUT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_HASH,
      FSM_PROBE,
      FSM_DONE
   } state_type;

endpackage

// ----- design/lpht_ram.sv -----
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/linear_probe_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressed hash table with linear probing, held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one word per operation (insert, search, delete) with key and
//    marks value. rsp channel: one word per request (status, marks, slot).
//  - After reset the table RAM is swept to empty, one slot per cycle, so
//    req_ready stays low until the sweep has written the last slot.
//  - One request is in flight at a time. Per request, in order: the accept
//    in FSM_IDLE, the home slot reduction in FSM_HASH (skipped when SLOTS is
//    a power of two), the probe walk in FSM_PROBE (one RAM read a cycle with
//    registered read data, probes = 1 .. SLOTS), and the load of the response
//    register in FSM_DONE. The probe walk runs over the single RAM read port.
//  - The response sits in an output register; a new request is accepted while
//    it waits. If the receiver stalls, a finished request waits in its final
//    state until the register is free, and no further request is taken.
//  - Insert/delete write back in the cycle the deciding entry is checked.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit #(
   parameter int SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lpht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lpht_pkg::rsp_type rsp_data
);

   import lpht_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = $bits(entry_type);
   localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);
   localparam logic [SW:0]     SLOTS_X   = (SW + 1)'(SLOTS);
   localparam logic [SW-1:0]   LAST_IDX  = SW'(SLOTS - 1);
   localparam logic [CW-1:0]   LAST_CNT  = CW'(SLOTS - 1);
   localparam logic [CW-1:0]   FULL_CNT  = CW'(SLOTS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HASH_STEPS - 1);

   function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   // control
   state_type            state_ff, state_in;
   logic [SW-1:0]        rd_idx_ff, rd_idx_in;      // also the clear pointer
   logic [CW-1:0]        rd_cnt_ff, rd_cnt_in;
   logic [SW-1:0]        chk_idx_ff, chk_idx_in;
   logic [CW-1:0]        chk_cnt_ff, chk_cnt_in;
   logic                 pend_ff, pend_in;          // read data valid this cycle
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   logic [1:0]           act_ff, act_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic [HASH_W-1:0]    key_sh_ff, key_sh_in;
   logic [SW-1:0]        rem_ff, rem_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // RAM port
   logic                 mem_we, mem_re;
   logic [SW-1:0]        mem_waddr, mem_raddr;
   entry_type            mem_wdata, mem_rdata;

   logic                 req_acc, act_ok, rsp_free, probe_done;
   logic [SW-1:0]        mod_next;
   logic [SLOT_OUT_W+SW-1:0] slot_ext;
   logic [SLOT_OUT_W-1:0]    chk_slot;

   assign req_ready = (state_ff == FSM_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign act_ok    = (req_data.action inside {ACT_INSERT, ACT_SEARCH, ACT_DELETE});
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // output slot number: index masked to the result field width
   assign slot_ext = {{SLOT_OUT_W{1'b0}}, chk_idx_ff};
   assign chk_slot = slot_ext[SLOT_OUT_W-1:0];

   // key mod SLOTS, one digit per cycle by restoring reduction
   always_comb begin
      logic [SW:0]   t;
      logic [SW-1:0] r;
      r = rem_ff;
      for (int i = 0; i < DIGIT_W; i++) begin
         t = {r, key_sh_ff[HASH_W-1-i]};
         if (t >= SLOTS_X) begin
            t = t - SLOTS_X;
         end
         r = t[SW-1:0];
      end
      mod_next = r;
   end

   lpht_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_CLEAR: begin
            if (rd_idx_ff == LAST_IDX) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_acc) begin
               if (!act_ok) begin
                  state_in = FSM_DONE;
               end else if (POW2) begin
                  state_in = FSM_PROBE;
               end else begin
                  state_in = FSM_HASH;
               end
            end
         end
         FSM_HASH: begin
            if (step_ff == STEP_LAST) begin
               state_in = FSM_PROBE;
            end
         end
         FSM_PROBE: begin
            if (probe_done) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (rsp_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      entry_type e;
      logic      hit_empty, hit_key, last;
      e           = mem_rdata;
      hit_empty   = (e.status == SLOT_EMPTY);
      hit_key     = (e.status == SLOT_USED) && (e.key == key_ff);
      last        = (chk_cnt_ff == LAST_CNT);

      rd_idx_in   = rd_idx_ff;
      rd_cnt_in   = rd_cnt_ff;
      chk_idx_in  = chk_idx_ff;
      chk_cnt_in  = chk_cnt_ff;
      pend_in     = 1'b0;
      step_in     = step_ff;
      act_in      = act_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      key_sh_in   = key_sh_ff;
      rem_in      = rem_ff;
      res_in      = res_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      probe_done  = 1'b0;

      mem_we      = 1'b0;
      mem_waddr   = chk_idx_ff;
      mem_wdata   = '0;
      mem_re      = 1'b0;
      mem_raddr   = rd_idx_ff;

      case (state_ff)
         FSM_CLEAR: begin
            mem_we           = 1'b1;
            mem_waddr        = rd_idx_ff;
            mem_wdata.status = SLOT_EMPTY;
            rd_idx_in        = wrap_inc(rd_idx_ff);
         end
         FSM_IDLE: begin
            if (req_acc) begin
               act_in     = req_data.action;
               key_in     = req_data.key;
               val_in     = req_data.value_in;
               key_sh_in  = {{(HASH_W - KEY_W){1'b0}}, req_data.key};
               step_in    = '0;
               rem_in     = '0;
               rd_idx_in  = req_data.key[SW-1:0];
               chk_idx_in = req_data.key[SW-1:0];
               rd_cnt_in  = '0;
               chk_cnt_in = '0;
               res_in.status    = RES_NOTFOUND;
               res_in.value_out = '0;
               res_in.slot      = '0;
            end
         end
         FSM_HASH: begin
            rem_in    = mod_next;
            key_sh_in = key_sh_ff << DIGIT_W;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               rd_idx_in  = mod_next;
               chk_idx_in = mod_next;
            end
         end
         FSM_PROBE: begin
            // reads run ahead of the check; nothing is written until the end
            if (pend_ff) begin
               if (act_ff == ACT_INSERT) begin
                  if (hit_empty) begin
                     mem_we           = 1'b1;
                     mem_wdata.status = SLOT_USED;
                     mem_wdata.key    = key_ff;
                     mem_wdata.value  = val_ff;
                     res_in.status    = RES_INSERTED;
                     res_in.slot      = chk_slot;
                     probe_done       = 1'b1;
                  end else if (last) begin
                     res_in.status    = RES_FULL;
                     probe_done       = 1'b1;
                  end
               end else begin
                  if (hit_empty) begin
                     res_in.status    = RES_NOTFOUND;
                     probe_done       = 1'b1;
                  end else if (hit_key) begin
                     if (act_ff == ACT_SEARCH) begin
                        res_in.status    = RES_FOUND;
                        res_in.value_out = e.value;
                     end else begin
                        mem_we           = 1'b1;
                        mem_wdata        = e;
                        mem_wdata.status = SLOT_TOMB;
                        res_in.status    = RES_DELETED;
                     end
                     res_in.slot = chk_slot;
                     probe_done  = 1'b1;
                  end else if (last) begin
                     res_in.status    = RES_NOTFOUND;
                     probe_done       = 1'b1;
                  end
               end
               if (!probe_done) begin
                  chk_idx_in = wrap_inc(chk_idx_ff);
                  chk_cnt_in = chk_cnt_ff + 1'b1;
               end
            end
            if (!probe_done && (rd_cnt_ff != FULL_CNT)) begin
               mem_re    = 1'b1;
               rd_idx_in = wrap_inc(rd_idx_ff);
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            pend_in = mem_re;
         end
         FSM_DONE: begin
            if (rsp_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         rd_idx_ff    <= '0;
         rd_cnt_ff    <= '0;
         chk_idx_ff   <= '0;
         chk_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         rd_cnt_ff    <= rd_cnt_in;
         chk_idx_ff   <= chk_idx_in;
         chk_cnt_ff   <= chk_cnt_in;
         pend_ff      <= pend_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      key_sh_ff   <= key_sh_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
